### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge and disabled while reset is low.
`define IQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules whose clock and reset are named clk and arst_n.
`define IQ_ASSERT(label, prop, msg) \
	`IQ_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

### rtl/core/iqfag_pkg.sv
`timescale 1ns / 1ps

package iqfag_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int IQ_WIDTH      = 16;
	localparam int PEAK_WIDTH    = 16;
	localparam int HANG_WIDTH    = 8;
	localparam int FRAME_WIDTH   = 32;
	localparam int CFG_WIDTH     = 16;
	localparam int CFG_IDX_WIDTH = 2;

	localparam logic [PEAK_WIDTH-1:0] THRESHOLD_RESET = PEAK_WIDTH'(100);
	localparam logic [HANG_WIDTH-1:0] HANGOVER_RESET  = HANG_WIDTH'(2);

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_PEAK_THRESHOLD  = 2'd0,
		REG_HANGOVER_LENGTH = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_PAUSE  = 1'b1
	} req_type_t;

	// Magnitude of the low SAMPLE_BITS bits taken as two's complement.
	// The most negative code maps to its full positive value.
	function automatic logic [PEAK_WIDTH-1:0] sample_magnitude(input logic [IQ_WIDTH-1:0] raw);
		logic [SAMPLE_BITS-1:0] v;
		logic [SAMPLE_BITS-1:0] m;
		v = raw[SAMPLE_BITS-1:0];
		if (v[SAMPLE_BITS-1]) begin
			m = ~v + 1'b1;
		end else begin
			m = v;
		end
		return PEAK_WIDTH'(m);
	endfunction

endpackage

### rtl/core/iq_frame_activity_gate_core.sv
`timescale 1ns / 1ps
// Result path: the last sample of a frame, once accepted, is held in the input register, and
// from there its result word is loaded into the result register when the output is not stalled.
// Throughput: one input word per cycle; the input stalls only while a result word is held
// by a stalled output and the word in the input register would produce another one.
// Reset: arst_n low clears all control and gate state and loads the register defaults.

module iq_frame_activity_gate_core
	import iqfag_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
	input  logic [CFG_WIDTH-1:0]          cfg_data,

	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic                          req_type,
	input  logic signed [IQ_WIDTH-1:0]    i_value,
	input  logic signed [IQ_WIDTH-1:0]    q_value,
	input  logic                          frame_end,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [FRAME_WIDTH-1:0]        frame_number,
	output logic [PEAK_WIDTH-1:0]         frame_peak,
	output logic                          frame_active,
	output logic                          send_preroll,
	output logic [FRAME_WIDTH-1:0]        preroll_number,
	output logic                          send_frame
);

	logic [PEAK_WIDTH-1:0]  peak_threshold_q;
	logic [HANG_WIDTH-1:0]  hangover_length_q;

	logic                   valid_s1;
	logic                   req_type_s1;
	logic [IQ_WIDTH-1:0]    i_value_s1;
	logic [IQ_WIDTH-1:0]    q_value_s1;
	logic                   frame_end_s1;

	logic [PEAK_WIDTH-1:0]  running_peak_q;
	logic [FRAME_WIDTH-1:0] frame_counter_q;
	logic [HANG_WIDTH-1:0]  hangover_left_q;
	logic                   previous_seen_q;
	logic                   sent_seen_q;
	logic [FRAME_WIDTH-1:0] last_sent_number_q;

	logic                   result_valid_q;

	logic                   in_accept;
	logic                   is_pause;
	logic                   produce;
	logic                   advance;
	logic [PEAK_WIDTH-1:0]  mag_i;
	logic [PEAK_WIDTH-1:0]  mag_q;
	logic [PEAK_WIDTH-1:0]  peak_mid;
	logic [PEAK_WIDTH-1:0]  peak_new;
	logic                   active;
	logic [FRAME_WIDTH-1:0] prev_number;
	logic                   preroll;
	logic                   send;

	always_comb begin
		is_pause    = (req_type_s1 == REQ_PAUSE);
		produce     = !is_pause && frame_end_s1;
		advance     = valid_s1 && (!produce || !result_valid_q || !result_stall);
		mag_i       = sample_magnitude(i_value_s1);
		mag_q       = sample_magnitude(q_value_s1);
		peak_mid    = (mag_i > running_peak_q) ? mag_i : running_peak_q;
		peak_new    = (mag_q > peak_mid) ? mag_q : peak_mid;
		active      = (peak_new >= peak_threshold_q);
		prev_number = frame_counter_q - 1'b1;
		preroll     = active && previous_seen_q &&
		              (!sent_seen_q || (last_sent_number_q != prev_number));
		send        = active || (hangover_left_q != '0);
	end

	assign sample_stall = valid_s1 && produce && result_valid_q && result_stall;
	assign in_accept    = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_threshold_q  <= THRESHOLD_RESET;
			hangover_length_q <= HANGOVER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK_THRESHOLD:  peak_threshold_q  <= cfg_data[PEAK_WIDTH-1:0];
				REG_HANGOVER_LENGTH: hangover_length_q <= cfg_data[HANG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1  <= req_type;
			i_value_s1   <= i_value;
			q_value_s1   <= q_value;
			frame_end_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_peak_q     <= '0;
			frame_counter_q    <= '0;
			hangover_left_q    <= '0;
			previous_seen_q    <= 1'b0;
			sent_seen_q        <= 1'b0;
			last_sent_number_q <= '0;
		end else if (advance) begin
			if (is_pause) begin
				running_peak_q  <= '0;
				hangover_left_q <= '0;
				previous_seen_q <= 1'b0;
				sent_seen_q     <= 1'b0;
			end else if (!frame_end_s1) begin
				running_peak_q <= peak_new;
			end else begin
				running_peak_q  <= '0;
				frame_counter_q <= frame_counter_q + 1'b1;
				previous_seen_q <= 1'b1;
				if (active) begin
					hangover_left_q <= hangover_length_q;
				end else if (hangover_left_q != '0) begin
					hangover_left_q <= hangover_left_q - 1'b1;
				end
				if (send) begin
					last_sent_number_q <= frame_counter_q;
					sent_seen_q        <= 1'b1;
				end else if (preroll) begin
					last_sent_number_q <= prev_number;
					sent_seen_q        <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && produce) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			frame_number   <= frame_counter_q;
			frame_peak     <= peak_new;
			frame_active   <= active;
			send_preroll   <= preroll;
			preroll_number <= preroll ? prev_number : '0;
			send_frame     <= send;
		end
	end

	assign result_valid = result_valid_q;

endmodule

### rtl/core/iqfag_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iqfag_checker
	import iqfag_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
	input  logic [CFG_WIDTH-1:0]          cfg_data,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  logic                          req_type,
	input  logic signed [IQ_WIDTH-1:0]    i_value,
	input  logic signed [IQ_WIDTH-1:0]    q_value,
	input  logic                          frame_end,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [FRAME_WIDTH-1:0]        frame_number,
	input  logic [PEAK_WIDTH-1:0]         frame_peak,
	input  logic                          frame_active,
	input  logic                          send_preroll,
	input  logic [FRAME_WIDTH-1:0]        preroll_number,
	input  logic                          send_frame
);

	// A stalled result word must hold.
	`IQ_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(frame_number) && $stable(frame_peak) && $stable(preroll_number), "stalled result word changed")

	// A preroll is only requested for an active frame.
	`IQ_ASSERT(a_preroll_active, result_valid && send_preroll |-> frame_active, "preroll without active frame")

	// An active frame is always sent.
	`IQ_ASSERT(a_active_sent, result_valid && frame_active |-> send_frame, "active frame not sent")

	// The preroll number names the frame just before this one and is zero otherwise.
	`IQ_ASSERT(a_preroll_number, result_valid |-> (send_preroll ? (preroll_number == frame_number - 1'b1) : (preroll_number == '0)), "bad preroll number")

endmodule

bind iq_frame_activity_gate_core iqfag_checker u_iqfag_checker (.*);
